### design/pdss_pkg.sv
// ----------------------------------------------------------------------------
// pdss_pkg: shared types and constants of the PDCCH search-space check
// Hash constants, field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pdss_pkg;

  // Field widths
  localparam int unsigned SfW   = 4;
  localparam int unsigned CfiW  = 2;
  localparam int unsigned RntiW = 16;
  localparam int unsigned CceW  = 7;
  localparam int unsigned HashW = 17;  // hash value ranges over 0..65536
  localparam int unsigned IterW = 5;   // subframe + 1, up to 16

  // Hash recursion Y = (HASH_MULT * Y) mod HASH_MOD, HASH_MOD = 2^16 + 1
  localparam logic [15:0] HASH_MULT = 16'd39827;
  localparam logic [17:0] HASH_MOD  = 18'd65537;

  // Common search space covers the first COMMON_LIMIT CCEs
  localparam logic [4:0] COMMON_LIMIT = 5'd16;

  // UE-specific candidate count minus one per level (levels 8,4 -> 1; 2,1 -> 5)
  localparam logic [2:0] LAST_CAND_HI = 3'd1;
  localparam logic [2:0] LAST_CAND_LO = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_CCE_CFI1 = 2'd0;
  localparam logic [1:0] CFG_CCE_CFI2 = 2'd1;
  localparam logic [1:0] CFG_CCE_CFI3 = 2'd2;

  // Format indicator codes
  localparam logic [1:0] CFI_NONE = 2'd0;
  localparam logic [1:0] CFI_ONE  = 2'd1;
  localparam logic [1:0] CFI_TWO  = 2'd2;
  localparam logic [1:0] CFI_THREE = 2'd3;

  // Hash unit phases
  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_RED
  } hash_ph_e;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LVL,
    S_DIV,
    S_CAND,
    S_FIN
  } seq_state_e;

endpackage

### design/pdss_hash.sv
// ----------------------------------------------------------------------------
// pdss_hash: iterated modular hash
// Runs Y = (39827 * Y) mod 65537 a given number of times from a 16-bit seed,
// with a multiply phase and a reduce phase per iteration.
// ----------------------------------------------------------------------------
module pdss_hash (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [15:0]             seed_i,
  input  logic [4:0]              iter_i,
  output logic                    done_o,
  output logic [16:0]             y_o
);
  import pdss_pkg::*;

  hash_ph_e          ph_q, ph_d;
  logic [HashW-1:0]  y_q, y_d;
  logic [31:0]       prod_q, prod_d;
  logic [IterW-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [17:0]       diff;

  // 2^16 = -1 mod 65537, so x mod 65537 = lo - hi, corrected once
  always_comb begin
    diff = {2'b00, prod_q[15:0]} - {2'b00, prod_q[31:16]};
    if (diff[17]) begin
      diff = diff + HASH_MOD;
    end
  end

  // Sequence multiply and reduce
  always_comb begin
    ph_d   = ph_q;
    y_d    = y_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (ph_q)
      H_IDLE: begin
        if (start_i) begin
          y_d   = {1'b0, seed_i};
          cnt_d = iter_i;
          ph_d  = H_MUL;
        end
      end
      H_MUL: begin
        prod_d = {16'd0, HASH_MULT} * {15'd0, y_q};
        ph_d   = H_RED;
      end
      H_RED: begin
        y_d   = diff[HashW-1:0];
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          done_d = 1'b1;
          ph_d   = H_IDLE;
        end else begin
          ph_d = H_MUL;
        end
      end
      default: ph_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= H_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

### design/pdss_mod.sv
// ----------------------------------------------------------------------------
// pdss_mod: serial remainder unit
// Restoring division of a 17-bit hash by a 7-bit nonzero divisor, one
// quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module pdss_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        done_o,
  output logic [6:0]  rem_o
);
  import pdss_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [HashW-1:0]  dvd_q, dvd_d;
  logic [CceW-1:0]   div_q, div_d;
  logic [CceW-1:0]   rem_q, rem_d;
  logic [CceW:0]     shifted;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[HashW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(HashW - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, div_q}) begin
        shifted = shifted - {1'b0, div_q};
      end
      rem_d = shifted[CceW-1:0];
      dvd_d = {dvd_q[HashW-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### design/pdcch_search_space_check.sv
// ----------------------------------------------------------------------------
// pdcch_search_space_check: PDCCH candidate start test
// Sequence: the hash runs subframe+1 iterations, then each aggregation level that fits
// the region has a setup step, a serial remainder and a walk over up to 6 candidates
// (2 at levels 8 and 4), left early on a hit; a result step then raises output valid.
// Input ready only while the sequencer idles, so a new word is accepted only
// after the result of the last one has been registered.
// Reset: asynchronous, active low; CCE count registers clear to zero.
// ----------------------------------------------------------------------------
module pdcch_search_space_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // subframe[3:0], cfi[5:4], rnti[21:6], cce_index[28:22]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // match[0]
);
  import pdss_pkg::*;

  logic [CceW-1:0]  cce_cfi1_q, cce_cfi2_q, cce_cfi3_q;

  seq_state_e       state_q, state_d;
  logic [CceW-1:0]  n_q, n_d;
  logic [CceW-1:0]  idx_q, idx_d;
  logic             com_q, com_d;
  logic             hit_q, hit_d;
  logic [1:0]       lv_q, lv_d;
  logic [2:0]       m_q, m_d;
  logic [CceW-1:0]  q_q, q_d;
  logic [CceW-1:0]  r_q, r_d;
  logic             out_valid_q, out_valid_d;
  logic             out_match_q, out_match_d;

  logic [SfW-1:0]   in_sf;
  logic [CfiW-1:0]  in_cfi;
  logic [RntiW-1:0] in_rnti;
  logic [CceW-1:0]  in_idx;
  logic [CceW-1:0]  in_n;
  logic [4:0]       com_lim;
  logic             in_com;
  logic             accept;

  logic             hash_done;
  logic [HashW-1:0] hash_y;
  logic             mod_start;
  logic             mod_done;
  logic [CceW-1:0]  mod_rem;
  logic [CceW-1:0]  lvl_q;
  logic [CceW-1:0]  cand_start;
  logic [CceW-1:0]  r_inc;
  logic [2:0]       last_m;

  // Unpack the input word
  assign in_sf   = s_axis_tdata[3:0];
  assign in_cfi  = s_axis_tdata[5:4];
  assign in_rnti = s_axis_tdata[21:6];
  assign in_idx  = s_axis_tdata[28:22];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Select the CCE region size by format indicator
  always_comb begin
    case (in_cfi)
      CFI_NONE:  in_n = '0;
      CFI_ONE:   in_n = cce_cfi1_q;
      CFI_TWO:   in_n = cce_cfi2_q;
      CFI_THREE: in_n = cce_cfi3_q;
      default:   in_n = '0;
    endcase
  end

  // Common candidates at levels 8 and 4 start at multiples of 4 whose four CCEs fit within min(N,16)
  assign com_lim = (in_n >= 7'(COMMON_LIMIT)) ? COMMON_LIMIT : in_n[4:0];
  assign in_com  = (in_idx[1:0] == 2'b00) &&
                   (({1'b0, in_idx} + 8'd4) <= {3'b000, com_lim});

  // Level geometry
  assign lvl_q      = n_q >> lv_q;
  assign cand_start = CceW'(r_q << lv_q);
  assign r_inc      = r_q + 7'd1;
  assign last_m     = lv_q[1] ? LAST_CAND_HI : LAST_CAND_LO;

  pdss_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .seed_i     (in_rnti),
    .iter_i     ({1'b0, in_sf} + 5'd1),
    .done_o     (hash_done),
    .y_o        (hash_y)
  );

  pdss_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (hash_y),
    .divisor_i  (lvl_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Sequence hash, per-level remainder and candidate walk
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    idx_d       = idx_q;
    com_d       = com_q;
    hit_d       = hit_q;
    lv_d        = lv_q;
    m_d         = m_q;
    q_d         = q_q;
    r_d         = r_q;
    mod_start   = 1'b0;
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d     = in_n;
          idx_d   = in_idx;
          com_d   = in_com;
          hit_d   = 1'b0;
          lv_d    = 2'd3;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_LVL;
        end
      end
      S_LVL: begin
        if (lvl_q == '0) begin
          // skip a level larger than the region
          if (lv_q == 2'd0) begin
            state_d = S_FIN;
          end else begin
            lv_d = lv_q - 2'd1;
          end
        end else begin
          q_d       = lvl_q;
          mod_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          r_d     = mod_rem;
          m_d     = '0;
          state_d = S_CAND;
        end
      end
      S_CAND: begin
        if (cand_start == idx_q) begin
          hit_d   = 1'b1;
          state_d = S_FIN;
        end else if (m_q == last_m) begin
          if (lv_q == 2'd0) begin
            state_d = S_FIN;
          end else begin
            lv_d    = lv_q - 2'd1;
            state_d = S_LVL;
          end
        end else begin
          // advance to the next candidate, wrapping at the level's slot count
          m_d = m_q + 3'd1;
          r_d = (r_inc == q_q) ? '0 : r_inc;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_match_d = hit_q || com_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    idx_q       <= idx_d;
    com_q       <= com_d;
    hit_q       <= hit_d;
    lv_q        <= lv_d;
    m_q         <= m_d;
    q_q         <= q_d;
    r_q         <= r_d;
    out_match_q <= out_match_d;
  end

  // Configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cce_cfi1_q <= '0;
      cce_cfi2_q <= '0;
      cce_cfi3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CCE_CFI1: cce_cfi1_q <= cfg_data_i;
        CFG_CCE_CFI2: cce_cfi2_q <= cfg_data_i;
        CFG_CCE_CFI3: cce_cfi3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_match_q};

endmodule
